// ===== rtl/lru_key_value_cache_top_defines.svh =====
// Assertion macros for the LRU key/value cache checker.
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define LKVC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

  localparam int KEY_W        = 32;
  localparam int VAL_W        = 32;
  localparam int CFG_W        = 5;
  localparam int CAPACITY_DEF = 16;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;

  localparam logic [APB_AW-1:0] REG_CAPACITY_ADDR  = 3'd0;
  localparam logic [CFG_W-1:0]  CAPACITY_RST_VALUE = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
  } out_rsp_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic req_get;
    logic out_blocked;
  } status_t;

endpackage

// ===== rtl/lkvc_ctrl.sv =====
// Request sequencer: idle, lookup and update states.
module lkvc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lkvc_pkg::status_t st,
  output lkvc_pkg::cmd_t    cmd
);
  import lkvc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       upd_done;
  logic       accept;

  assign upd_done = (state_r == ST_UPD) && !(st.req_get && st.out_blocked);
  assign in_ready = (state_r == ST_IDLE) || upd_done;
  assign accept   = in_valid && in_ready;

  assign cmd.load    = accept;
  assign cmd.capture = (state_r == ST_LOOK);
  assign cmd.commit  = upd_done;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (upd_done) state_nxt = accept ? ST_LOOK : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/lkvc_dp.sv =====
// Datapath: entry rows, value memory, recency ranks and result register.
module lkvc_dp #(
  parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lkvc_pkg::in_req_t          in_data,
  input  lkvc_pkg::cmd_t             cmd,
  output lkvc_pkg::status_t          st,
  input  logic [lkvc_pkg::CFG_W-1:0] cap_cfg,
  input  logic                       out_ready,
  output logic                       out_valid,
  output lkvc_pkg::out_rsp_t         out_data
);
  import lkvc_pkg::*;

  localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > CFG_W) ? CW : CFG_W;

  in_req_t              req_r;
  logic [CAPACITY-1:0]  valid_r;
  logic [CAPACITY-1:0]  valid_nxt;
  logic [KEY_W-1:0]     key_r    [CAPACITY];
  logic [RW-1:0]        rank_r   [CAPACITY];
  logic [RW-1:0]        rank_nxt [CAPACITY];
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic [VAL_W-1:0]     val_mem  [CAPACITY];
  logic [VAL_W-1:0]     rd_data_r;

  logic [CAPACITY-1:0]  match_oh;
  logic [CAPACITY-1:0]  victim_oh;
  logic [CAPACITY-1:0]  free_oh;
  logic [CAPACITY-1:0]  tgt_oh;
  logic [RW-1:0]        hit_idx;
  logic [RW-1:0]        hit_rank;
  logic [RW-1:0]        lru_rank;
  logic [EW-1:0]        cap_ext;
  logic [EW-1:0]        eff_cap;
  logic                 hit;
  logic                 evict;

  logic                 hit_r;
  logic                 evict_r;
  logic [CAPACITY-1:0]  tgt_oh_r;
  logic [RW-1:0]        tgt_idx_r;
  logic [RW-1:0]        tgt_idx;
  logic [RW-1:0]        hit_rank_r;
  logic                 is_put;

  logic                 out_valid_r;
  out_rsp_t             out_data_r;

  assign is_put   = (req_r.operation == OP_PUT);
  assign lru_rank = RW'(count_r - CW'(1));
  assign free_oh  = ~valid_r & (valid_r + CAPACITY'(1));

  always_comb begin
    hit_idx  = '0;
    hit_rank = '0;
    tgt_idx  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_oh[i]  = valid_r[i] && (key_r[i] == req_r.key);
      victim_oh[i] = valid_r[i] && (rank_r[i] == lru_rank);
      if (match_oh[i]) begin
        hit_idx  = hit_idx | RW'(i);
        hit_rank = hit_rank | rank_r[i];
      end
    end
    hit = |match_oh;
    cap_ext = EW'(cap_cfg);
    if (cap_ext == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(CAPACITY)) begin
      eff_cap = EW'(CAPACITY);
    end else begin
      eff_cap = cap_ext;
    end
    evict = (EW'(count_r) >= eff_cap);
    if (hit) begin
      tgt_oh = match_oh;
    end else if (evict) begin
      tgt_oh = victim_oh;
    end else begin
      tgt_oh = free_oh;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (tgt_oh[i]) tgt_idx = tgt_idx | RW'(i);
    end
  end

  // Latch the request, capture lookup outcome and read the hit entry's value.
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
    if (cmd.capture) begin
      hit_r      <= hit;
      evict_r    <= evict;
      tgt_oh_r   <= tgt_oh;
      tgt_idx_r  <= tgt_idx;
      hit_rank_r <= hit_rank;
      rd_data_r  <= val_mem[hit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && is_put) val_mem[tgt_idx_r] <= req_r.value;
  end

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < CAPACITY; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (cmd.commit) begin
      if (hit_r) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (tgt_oh_r[i]) begin
            rank_nxt[i] = '0;
          end else if (valid_r[i] && (rank_r[i] < hit_rank_r)) begin
            rank_nxt[i] = rank_r[i] + RW'(1);
          end
        end
      end else if (is_put) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (tgt_oh_r[i]) begin
            valid_nxt[i] = 1'b1;
            rank_nxt[i]  = '0;
          end else if (valid_r[i]) begin
            rank_nxt[i] = rank_r[i] + RW'(1);
          end
        end
        if (!evict_r) count_nxt = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.commit && is_put && !hit_r && tgt_oh_r[i]) key_r[i] <= req_r.key;
    end
  end

  // Hold the result until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit && !is_put) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !is_put) begin
      out_data_r.found      <= hit_r;
      out_data_r.read_value <= hit_r ? rd_data_r : '1;
    end
  end

  assign st.req_get     = !is_put;
  assign st.out_blocked = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

endmodule

// ===== rtl/lru_key_value_cache_top.sv =====
// Top level of the LRU key/value cache with its configuration register.
// Fully associative store of CAPACITY key/value pairs with least-recently-used
// replacement. Each request passes a lookup cycle, which compares the key
// against every entry in parallel and picks the hit, free or victim entry,
// and an update cycle, which rewrites the recency ranks on a hit or a put and,
// for a put, writes the value memory. A new request can be taken in the update
// cycle as well as when idle; a get waits in the update cycle while the previous
// result still sits unaccepted in the output register. A get's result is
// registered at the end of its update cycle and appears in the cycle after. The
// store is empty right after reset; no clearing pass is needed.
module lru_key_value_cache_top #(
  parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lkvc_pkg::in_req_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lkvc_pkg::out_rsp_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lkvc_pkg::APB_AW-1:0] paddr,
  input  logic [lkvc_pkg::APB_DW-1:0] pwdata,
  output logic [lkvc_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import lkvc_pkg::*;

  cmd_t             cmd;
  status_t          st;
  logic [CFG_W-1:0] cap_r;
  logic             cap_sel;

  assign pready  = 1'b1;
  assign cap_sel = (paddr == REG_CAPACITY_ADDR);
  assign prdata  = cap_sel ? APB_DW'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAPACITY_RST_VALUE;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      cap_r <= pwdata[CFG_W-1:0];
    end
  end

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lkvc_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .cap_cfg   (cap_r),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/lkvc_checker.sv =====
// Port-level checker for the LRU key/value cache, bound to the top level.
`include "lru_key_value_cache_top_defines.svh"

module lkvc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input lkvc_pkg::out_rsp_t out_data
);
  import lkvc_pkg::*;

  logic out_stall;
  logic out_miss;

  assign out_stall = out_valid && !out_ready;
  assign out_miss  = out_valid && !out_data.found;

  `LKVC_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "result not held")
  `LKVC_ASSERT_NOW(a_miss_ones, out_miss, out_data.read_value == '1, "bad miss value")
  `LKVC_ASSERT_NEXT(a_two_cycle, in_valid && in_ready, !in_ready, "ready in lookup cycle")

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (.*);
